>>> design/assert_macros.svh
// Assertion macros for the frame receiver top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/bsfr_pkg.sv
// Types and constants of the byte-stuffed frame receiver.
`timescale 1ns / 1ps

package bsfr_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7F;
    localparam logic [7:0] ESC_FLAG  = 8'h80;
    localparam logic [7:0] ESC_ESC   = 8'h81;

    localparam logic [7:0] CHECKSUM_RESET  = 8'h55;
    localparam logic [5:0] MIN_FRAME_RESET = 6'd3;
    localparam logic [5:0] PLEN_MAX        = 6'd63;

    localparam logic CFG_CHECKSUM  = 1'b0;
    localparam logic CFG_MIN_FRAME = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef enum logic [2:0] {
        ST_GOOD     = 3'd0,
        ST_CHECKSUM = 3'd1,
        ST_BAD_ESC  = 3'd2,
        ST_SHORT    = 3'd3,
        ST_OVERFLOW = 3'd4
    } bsfr_status_t;

    typedef enum logic {
        PH_FIRST  = 1'b0,
        PH_REPORT = 1'b1
    } bsfr_phase_t;

    typedef struct packed {
        logic         has_data;
        logic [7:0]   data;
        logic         has_rep;
        bsfr_status_t status;
        logic [5:0]   plen;
    } bsfr_cmd_t;

endpackage

>>> design/byte_stuffed_frame_receiver.sv
// Path: each result item is written into the queue and then loaded into the output register;
// the second result of a byte (dangling escape before a report) follows from the same entry.
// Throughput: one raw byte per cycle while the queue is not full; one result item per cycle
// while out_stall is low; the four-entry queue absorbs two-result bytes and downstream stalls.
// Reset: asynchronous, active low; clears frame state and queue, loads register defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module byte_stuffed_frame_receiver
    import bsfr_pkg::*;
#(
    parameter int MAX_FRAME = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] data_value,
    output logic [2:0] frame_status,
    output logic [5:0] payload_length,
    output logic       is_last
);

    logic         take;
    logic         push;
    bsfr_cmd_t    push_cmd;
    logic         pop;
    bsfr_cmd_t    head;
    logic         empty;
    logic         full;
    bsfr_status_t status_w;

    assign rx_stall = full;
    assign take     = rx_valid && !full;

    bsfr_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .rx_byte   (rx_byte),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    bsfr_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    bsfr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .empty          (empty),
        .pop            (pop),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .kind           (kind),
        .data_value     (data_value),
        .frame_status   (status_w),
        .payload_length (payload_length),
        .is_last        (is_last)
    );

    assign frame_status = status_w;

    `ASSERT_SAME(a_report_last, out_valid && kind, is_last, "frame report not last")
    `ASSERT_SAME(a_data_clean, out_valid && !kind,
                 frame_status == ST_GOOD && payload_length == 6'd0,
                 "data item carries status or length")
    `ASSERT_SAME(a_len_good_only, out_valid && kind && frame_status != ST_GOOD,
                 payload_length == 6'd0, "length on failed frame")
    `ASSERT_NEXT(a_data_then_more, out_valid && !out_stall && !kind && !is_last,
                 out_valid && kind, "dangling escape not followed by report")

endmodule

>>> design/bsfr_front.sv
// Front end: configuration, frame state and classification of each raw byte.
`timescale 1ns / 1ps

module bsfr_front
    import bsfr_pkg::*;
#(
    parameter int MAX_FRAME = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       take,
    input  logic [7:0] rx_byte,
    output logic       push,
    output bsfr_cmd_t  push_cmd
);

    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam int XW = (CW > 6) ? CW : 6;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAME);

    logic [7:0]    target_reg;
    logic [5:0]    min_reg;
    logic [CW-1:0] raw_reg, raw_next;
    logic [CW-1:0] dc_reg, dc_next;
    logic [7:0]    sum_reg, sum_next;
    logic          pend_reg, pend_next;
    logic          err_reg, err_next;

    logic          dangle;
    logic [7:0]    sum_fin;
    logic [CW-1:0] dc_fin;
    logic [CW-1:0] dc_m1;
    logic [5:0]    plen_sat;
    logic          emit;
    logic [7:0]    emit_val;
    bsfr_cmd_t     cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= CHECKSUM_RESET;
            min_reg    <= MIN_FRAME_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHECKSUM:  target_reg <= cfg_data;
                CFG_MIN_FRAME: min_reg    <= cfg_data[5:0];
                default:       target_reg <= target_reg;
            endcase
        end
    end

    always_comb
    begin
        dangle   = pend_reg && !err_reg;
        sum_fin  = sum_reg + (dangle ? ESC_BYTE : 8'h00);
        dc_fin   = dc_reg + CW'(dangle);
        dc_m1    = (dc_fin != '0) ? dc_fin - CW'(1) : '0;
        plen_sat = (XW'(dc_m1) > XW'(PLEN_MAX)) ? PLEN_MAX : 6'(dc_m1);

        raw_next  = raw_reg;
        dc_next   = dc_reg;
        sum_next  = sum_reg;
        pend_next = pend_reg;
        err_next  = err_reg;
        emit      = 1'b0;
        emit_val  = rx_byte;
        cmd       = '{has_data: 1'b0, data: 8'h00, has_rep: 1'b0,
                      status: ST_GOOD, plen: 6'd0};

        if (take)
        begin
            if (rx_byte == FLAG_BYTE)
            begin
                if (raw_reg != '0)
                begin
                    cmd.has_data = dangle;
                    cmd.data     = dangle ? ESC_BYTE : 8'h00;
                    cmd.has_rep  = 1'b1;
                    if (XW'(raw_reg) < XW'(min_reg))
                        cmd.status = ST_SHORT;
                    else if (err_reg)
                        cmd.status = ST_BAD_ESC;
                    else if (sum_fin == target_reg)
                    begin
                        cmd.status = ST_GOOD;
                        cmd.plen   = plen_sat;
                    end
                    else
                        cmd.status = ST_CHECKSUM;
                end
                raw_next  = '0;
                dc_next   = '0;
                sum_next  = '0;
                pend_next = 1'b0;
                err_next  = 1'b0;
            end
            else if (raw_reg >= MAX_CNT)
            begin
                cmd.has_rep = 1'b1;
                cmd.status  = ST_OVERFLOW;
                raw_next    = '0;
                dc_next     = '0;
                sum_next    = '0;
                pend_next   = 1'b0;
                err_next    = 1'b0;
            end
            else
            begin
                raw_next = raw_reg + CW'(1);
                if (err_reg)
                    pend_next = 1'b0;
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                    if (rx_byte == ESC_FLAG)
                    begin
                        emit     = 1'b1;
                        emit_val = FLAG_BYTE;
                    end
                    else if (rx_byte == ESC_ESC)
                    begin
                        emit     = 1'b1;
                        emit_val = ESC_BYTE;
                    end
                    else
                        err_next = 1'b1;
                end
                else if (rx_byte == ESC_BYTE)
                    pend_next = 1'b1;
                else
                    emit = 1'b1;

                if (emit)
                begin
                    dc_next      = dc_reg + CW'(1);
                    sum_next     = sum_reg + emit_val;
                    cmd.has_data = 1'b1;
                    cmd.data     = emit_val;
                end
            end
        end
    end

    assign push     = take && (cmd.has_data || cmd.has_rep);
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg  <= '0;
            dc_reg   <= '0;
            sum_reg  <= '0;
            pend_reg <= 1'b0;
            err_reg  <= 1'b0;
        end
        else
        begin
            raw_reg  <= raw_next;
            dc_reg   <= dc_next;
            sum_reg  <= sum_next;
            pend_reg <= pend_next;
            err_reg  <= err_next;
        end
    end

endmodule

>>> design/bsfr_fifo.sv
// Short queue of classified items between front and back end.
`timescale 1ns / 1ps

module bsfr_fifo
    import bsfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  bsfr_cmd_t push_cmd,
    input  logic      pop,
    output bsfr_cmd_t head,
    output logic      empty,
    output logic      full
);

    bsfr_cmd_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> design/bsfr_back.sv
// Back end: expand queued items into result items behind an output register.
`timescale 1ns / 1ps

module bsfr_back
    import bsfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  bsfr_cmd_t    head,
    input  logic         empty,
    output logic         pop,
    input  logic         out_stall,
    output logic         out_valid,
    output logic         kind,
    output logic [7:0]   data_value,
    output bsfr_status_t frame_status,
    output logic [5:0]   payload_length,
    output logic         is_last
);

    bsfr_phase_t  phase_reg, phase_next;
    logic         out_valid_reg, out_valid_next;
    logic         kind_reg, kind_next;
    logic [7:0]   data_reg, data_next;
    bsfr_status_t status_reg, status_next;
    logic [5:0]   plen_reg, plen_next;
    logic         last_reg, last_next;
    logic         load;
    logic         send_data;

    assign load = !empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        phase_next = phase_reg;
        if (load)
        begin
            unique case (phase_reg)
                PH_FIRST:
                    if (head.has_data && head.has_rep)
                        phase_next = PH_REPORT;
                PH_REPORT:
                    phase_next = PH_FIRST;
                default:
                    phase_next = PH_FIRST;
            endcase
        end
    end

    always_comb
    begin
        send_data      = (phase_reg == PH_FIRST) && head.has_data;
        pop            = load && !(send_data && head.has_rep);
        out_valid_next = load || (out_valid_reg && out_stall);
        if (send_data)
        begin
            kind_next   = 1'b0;
            data_next   = head.data;
            status_next = ST_GOOD;
            plen_next   = 6'd0;
            last_next   = !head.has_rep;
        end
        else
        begin
            kind_next   = 1'b1;
            data_next   = 8'h00;
            status_next = head.status;
            plen_next   = head.plen;
            last_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= kind_next;
            data_reg   <= data_next;
            status_reg <= status_next;
            plen_reg   <= plen_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign data_value     = data_reg;
    assign frame_status   = status_reg;
    assign payload_length = plen_reg;
    assign is_last        = last_reg;

endmodule

>>> verif/deframe_checker.sv
`timescale 1ns / 1ps
// Checker for the frame receiver: predicts every output item and compares it on arrival.

module deframe_checker
    import bsfr_pkg::*;
#(
    parameter int MAX_FRAME = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       rx_valid,
    input  logic       rx_stall,
    input  logic [7:0] rx_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       kind,
    input  logic [7:0] data_value,
    input  logic [2:0] frame_status,
    input  logic [5:0] payload_length,
    input  logic       is_last,
    output int         fail_count,
    output int         pending,
    output int         checked
);

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [2:0] status;
        logic [5:0] plen;
        logic       last;
    } frame_item_t;

    frame_item_t frame_results_q[$];
    frame_item_t step_items[$];
    frame_item_t want;

    logic [7:0] sum_target;
    logic [5:0] min_bytes;
    int         raw_count;
    int         decoded_count;
    logic [7:0] running_sum;
    logic       esc_pending;
    logic       esc_error;
    int         errs;

    function automatic frame_item_t make_item(input logic k, input logic [7:0] d,
                                              input logic [2:0] s, input logic [5:0] p);
        frame_item_t it;
        it.kind   = k;
        it.data   = d;
        it.status = s;
        it.plen   = p;
        it.last   = 1'b0;
        return it;
    endfunction

    function automatic int field_mismatch(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    task automatic clear_frame_state();
        raw_count     = 0;
        decoded_count = 0;
        running_sum   = 8'd0;
        esc_pending   = 1'b0;
        esc_error     = 1'b0;
    endtask

    task automatic emit_decoded(input logic [7:0] v);
        running_sum = running_sum + v;
        decoded_count++;
        step_items.push_back(make_item(1'b0, v, ST_GOOD, 6'd0));
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        bsfr_status_t status;
        logic [5:0]   plen;
        int           n_payload;
        step_items.delete();
        if (b == FLAG_BYTE)
        begin
            if (raw_count != 0)
            begin
                if (esc_pending && !esc_error)
                    emit_decoded(ESC_BYTE);
                plen = 6'd0;
                if (raw_count < min_bytes)
                    status = ST_SHORT;
                else if (esc_error)
                    status = ST_BAD_ESC;
                else if (running_sum == sum_target)
                begin
                    status    = ST_GOOD;
                    n_payload = (decoded_count > 0) ? decoded_count - 1 : 0;
                    plen      = (n_payload > PLEN_MAX) ? PLEN_MAX : n_payload[5:0];
                end
                else
                    status = ST_CHECKSUM;
                step_items.push_back(make_item(1'b1, 8'd0, status, plen));
            end
            clear_frame_state();
        end
        else if (raw_count >= MAX_FRAME)
        begin
            step_items.push_back(make_item(1'b1, 8'd0, ST_OVERFLOW, 6'd0));
            clear_frame_state();
        end
        else
        begin
            raw_count++;
            if (esc_error)
                esc_pending = 1'b0;
            else if (esc_pending)
            begin
                esc_pending = 1'b0;
                if (b == ESC_FLAG)
                    emit_decoded(FLAG_BYTE);
                else if (b == ESC_ESC)
                    emit_decoded(ESC_BYTE);
                else
                    esc_error = 1'b1;
            end
            else if (b == ESC_BYTE)
                esc_pending = 1'b1;
            else
                emit_decoded(b);
        end
        if (step_items.size() > 0)
            step_items[step_items.size() - 1].last = 1'b1;
        foreach (step_items[i])
            frame_results_q.push_back(step_items[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_target = CHECKSUM_RESET;
            min_bytes  = MIN_FRAME_RESET;
            clear_frame_state();
            frame_results_q.delete();
            fail_count <= 0;
            pending    <= 0;
            checked    <= 0;
        end
        else
        begin
            errs = 0;
            if (out_valid && !out_stall)
            begin
                if (frame_results_q.size() == 0)
                begin
                    $error("output item with none expected: kind %0d data %0d status %0d",
                           kind, data_value, frame_status);
                    errs = 1;
                end
                else
                begin
                    want = frame_results_q.pop_front();
                    errs += field_mismatch("kind", want.kind, kind);
                    errs += field_mismatch("data_value", want.data, data_value);
                    errs += field_mismatch("frame_status", want.status, frame_status);
                    errs += field_mismatch("payload_length", want.plen, payload_length);
                    errs += field_mismatch("is_last", want.last, is_last);
                    checked <= checked + 1;
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_CHECKSUM)
                    sum_target = cfg_data;
                else
                    min_bytes = cfg_data[5:0];
            end
            if (rx_valid && !rx_stall)
                deframe_byte(rx_byte);
            fail_count <= fail_count + errs;
            pending    <= frame_results_q.size();
        end
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Top of the frame receiver testbench: clock, reset, byte stimulus, settings and verdict.

module testbench;
    import bsfr_pkg::*;

    localparam int MAX_FRAME    = 64;
    localparam int HOLD_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_BYTES  = 200;
    localparam int NUM_PHASES   = 5;

    typedef enum {FR_GOOD, FR_BAD_SUM, FR_BAD_ESC, FR_DANGLING} frame_mode_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;
    logic       rx_valid;
    logic       rx_stall;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic       kind;
    logic [7:0] data_value;
    logic [2:0] frame_status;
    logic [5:0] payload_length;
    logic       is_last;

    int         fail_count;
    int         pending;
    int         checked;
    int         cycle_count;
    int         bytes_sent;
    logic       idling;
    logic       hold_req;
    logic [7:0] link_target;
    logic [7:0] payload_q[$];

    byte_stuffed_frame_receiver #(.MAX_FRAME(MAX_FRAME)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .rx_valid      (rx_valid),
        .rx_stall      (rx_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .data_value    (data_value),
        .frame_status  (frame_status),
        .payload_length(payload_length),
        .is_last       (is_last)
    );

    deframe_checker #(.MAX_FRAME(MAX_FRAME)) frame_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .rx_valid      (rx_valid),
        .rx_stall      (rx_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .data_value    (data_value),
        .frame_status  (frame_status),
        .payload_length(payload_length),
        .is_last       (is_last),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d items still expected", cycle_count, pending);
        $display("status: fail");
        $finish;
    end

    // receiver side: random stalls, plus a long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            out_stall <= idling && ($urandom_range(0, 99) < 24);
        end
    end

    function automatic logic [7:0] pick_byte();
        logic [7:0] special[6] = '{8'h00, 8'hFF, FLAG_BYTE, ESC_BYTE, ESC_FLAG, ESC_ESC};
        if ($urandom_range(0, 99) < 25)
            return special[$urandom_range(0, 5)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while (idling && $urandom_range(0, 99) < 24)
        begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (rx_stall);
        bytes_sent++;
    endtask

    task automatic rx_quiet();
        rx_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_frame(input logic [7:0] payload[$], input frame_mode_t mode);
        logic [7:0] raw[$];
        logic [7:0] cks;
        logic [7:0] bad;
        int         pos;
        cks = link_target;
        foreach (payload[i])
            cks = cks - payload[i];
        if (mode == FR_BAD_SUM)
            cks = cks + 8'($urandom_range(1, 255));
        payload.push_back(cks);
        foreach (payload[i])
        begin
            if (payload[i] == FLAG_BYTE)
            begin
                raw.push_back(ESC_BYTE);
                raw.push_back(ESC_FLAG);
            end
            else if (payload[i] == ESC_BYTE)
            begin
                raw.push_back(ESC_BYTE);
                raw.push_back(ESC_ESC);
            end
            else
                raw.push_back(payload[i]);
        end
        if (mode == FR_BAD_ESC)
        begin
            do
                bad = 8'($urandom_range(0, 255));
            while (bad inside {ESC_FLAG, ESC_ESC, FLAG_BYTE});
            pos = $urandom_range(0, raw.size());
            raw.insert(pos, bad);
            raw.insert(pos, ESC_BYTE);
        end
        if (mode == FR_DANGLING)
            raw.push_back(ESC_BYTE);
        raw.push_back(FLAG_BYTE);
        if ($urandom_range(0, 9) == 0)
            raw.push_front(FLAG_BYTE);
        foreach (raw[i])
            send_byte(raw[i]);
    endtask

    task automatic random_frame();
        int          pick;
        int          len;
        frame_mode_t mode;
        logic [7:0]  body[$];
        pick = $urandom_range(0, 99);
        if (pick >= 86)
        begin
            // noise with stray flags
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++)
                send_byte(($urandom_range(0, 4) == 0) ? FLAG_BYTE : pick_byte());
        end
        else
        begin
            mode = (pick < 55) ? FR_GOOD : (pick < 67) ? FR_BAD_SUM :
                   (pick < 77) ? FR_BAD_ESC : FR_DANGLING;
            if ($urandom_range(0, 99) < 7)
                len = $urandom_range(62, 75);
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(13, 45);
            else
                len = $urandom_range(0, 12);
            for (int i = 0; i < len; i++)
                body.push_back(pick_byte());
            send_frame(body, mode);
        end
    endtask

    task automatic change_settings(input logic [7:0] target, input logic [5:0] min_len);
        rx_quiet();
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CHECKSUM;
        cfg_data  <= target;
        @(posedge clk);
        cfg_index <= CFG_MIN_FRAME;
        cfg_data  <= {2'b00, min_len};
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        link_target = target;
    endtask

    initial
    begin
        logic [7:0] targets[NUM_PHASES];
        logic [5:0] mins[NUM_PHASES];
        int         goal;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_CHECKSUM;
        cfg_data    = 8'd0;
        rx_valid    = 1'b0;
        rx_byte     = 8'd0;
        idling      = 1'b1;
        hold_req    = 1'b0;
        bytes_sent  = 0;
        link_target = CHECKSUM_RESET;
        targets = '{8'd0, 8'd255, CHECKSUM_RESET, 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255))};
        mins    = '{6'd1, 6'd63, MIN_FRAME_RESET, 6'd0, 6'($urandom_range(1, 63))};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty frames, escapes, bad checksum, bad escape, dangling escape, short frame
        send_byte(FLAG_BYTE);
        send_byte(FLAG_BYTE);
        payload_q = {8'h00, 8'hFF, FLAG_BYTE, ESC_BYTE};
        send_frame(payload_q, FR_GOOD);
        payload_q = {8'h01, 8'h02};
        send_frame(payload_q, FR_BAD_SUM);
        payload_q = {8'h41};
        send_frame(payload_q, FR_BAD_ESC);
        payload_q = {8'h10, 8'h20};
        send_frame(payload_q, FR_DANGLING);
        send_byte(8'h01);
        send_byte(FLAG_BYTE);
        // overflow: frame longer than MAX_FRAME
        for (int i = 0; i < 70; i++)
            send_byte(8'($urandom_range(0, 255)) & 8'h3F);
        send_byte(FLAG_BYTE);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            change_settings(targets[p], mins[p]);
            idling = (p != 1);
            if (p == 2)
                hold_req = 1'b1;
            goal = bytes_sent + PHASE_BYTES;
            while (bytes_sent < goal)
                random_frame();
        end

        rx_quiet();
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d raw bytes over %0d register settings, %0d output items checked",
                 bytes_sent, NUM_PHASES + 1, checked);
        $display("frames: good, bad checksum, bad escape, dangling escape, short and overflow");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/bsfr_pkg.sv
design/bsfr_front.sv
design/bsfr_fifo.sv
design/bsfr_back.sv
design/byte_stuffed_frame_receiver.sv
verif/deframe_checker.sv
verif/testbench.sv
